[rtl/h20_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h20_pkg
// Shared types, constants and the node table of the 20-node hexahedron
// shape function evaluator.
// ----------------------------------------------------------------------------
package h20_pkg;

    localparam int FRAC_BITS  = 14;
    localparam int NODE_COUNT = 20;
    localparam int SCALE      = 1 << FRAC_BITS;
    localparam int FW         = 20;     // signed factor width
    localparam int MW         = 18;     // factor magnitude width
    localparam int PW         = 4 * MW; // full product width

    localparam logic [4:0] LAST_NODE = 5'(NODE_COUNT - 1);

    // rounding shift selector
    localparam logic [2:0] K_CORNER_VAL = 3'd0; // 3F+3
    localparam logic [2:0] K_CORNER_DER = 3'd1; // 2F+3
    localparam logic [2:0] K_EDGE_VAL   = 3'd2; // 3F+2
    localparam logic [2:0] K_EDGE_AXIS  = 3'd3; // 2F+1
    localparam logic [2:0] K_EDGE_SIDE  = 3'd4; // 2F+2

    typedef struct packed {
        logic       valid;
        logic [4:0] node;
    } h20_tag_t;

    typedef struct packed {
        logic                   neg;
        logic [2:0]             kcode;
        logic [3:0][MW-1:0]     mag;
    } h20_lane_op_t;

    typedef logic signed [1:0] h20_pos_t;

    // node position per axis (xi, eta, zeta), each -1, 0 or 1
    function automatic logic [2:0][1:0] node_pos(input logic [4:0] n);
        logic [2:0][1:0] r;
        r = '0;
        case (n)
            5'd0:  r = {2'b11, 2'b11, 2'b11};
            5'd1:  r = {2'b11, 2'b11, 2'b01};
            5'd2:  r = {2'b11, 2'b01, 2'b01};
            5'd3:  r = {2'b11, 2'b01, 2'b11};
            5'd4:  r = {2'b01, 2'b11, 2'b11};
            5'd5:  r = {2'b01, 2'b11, 2'b01};
            5'd6:  r = {2'b01, 2'b01, 2'b01};
            5'd7:  r = {2'b01, 2'b01, 2'b11};
            5'd8:  r = {2'b11, 2'b11, 2'b00};
            5'd9:  r = {2'b11, 2'b00, 2'b01};
            5'd10: r = {2'b11, 2'b01, 2'b00};
            5'd11: r = {2'b11, 2'b00, 2'b11};
            5'd12: r = {2'b01, 2'b11, 2'b00};
            5'd13: r = {2'b01, 2'b00, 2'b01};
            5'd14: r = {2'b01, 2'b01, 2'b00};
            5'd15: r = {2'b01, 2'b00, 2'b11};
            5'd16: r = {2'b00, 2'b11, 2'b11};
            5'd17: r = {2'b00, 2'b11, 2'b01};
            5'd18: r = {2'b00, 2'b01, 2'b01};
            5'd19: r = {2'b00, 2'b01, 2'b11};
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

[rtl/h20_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h20_seq
// Holds the current point and steps through the twenty nodes, one per
// advancing cycle; takes the next point while the last node goes out.
// ----------------------------------------------------------------------------
module h20_seq
    import h20_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [2:0][15:0]  coord_in,
    output h20_tag_t          tag,
    output logic [2:0][15:0]  coord
);

    logic             busy_reg, busy_next;
    logic [4:0]       node_reg, node_next;
    logic [2:0][15:0] coord_reg;

    assign s_tready = en && (!busy_reg || node_reg == LAST_NODE);

    always_comb begin
        busy_next = busy_reg;
        node_next = node_reg;
        if (s_tvalid && s_tready) begin
            busy_next = 1'b1;
            node_next = '0;
        end else if (en && busy_reg) begin
            if (node_reg == LAST_NODE) begin
                busy_next = 1'b0;
            end else begin
                node_next = node_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            node_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            node_reg <= node_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            coord_reg <= coord_in;
        end
    end

    assign tag   = '{valid: busy_reg, node: node_reg};
    assign coord = coord_reg;

endmodule

[rtl/h20_factor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h20_factor
// Forms the four signed factors, the sign and the rounding shift of each
// output lane for one node, and registers them as magnitudes.
// ----------------------------------------------------------------------------
module h20_factor
    import h20_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  h20_tag_t               tag_in,
    input  logic [2:0][15:0]       coord,
    output h20_tag_t               tag,
    output h20_lane_op_t [3:0]     ops
);

    localparam logic signed [FW-1:0] S_F   = FW'(SCALE);
    localparam logic signed [FW-1:0] ONE_F = FW'(1);

    h20_tag_t          tag_reg;
    h20_lane_op_t [3:0] ops_reg, ops_next;

    function automatic logic [MW-1:0] fmag(input logic signed [FW-1:0] v);
        logic [FW-1:0] a;
        a = v[FW-1] ? -v : v;
        return a[MW-1:0];
    endfunction

    function automatic h20_lane_op_t mk_op(input logic signed [FW-1:0] f0,
                                           input logic signed [FW-1:0] f1,
                                           input logic signed [FW-1:0] f2,
                                           input logic signed [FW-1:0] f3,
                                           input logic xneg,
                                           input logic [2:0] k);
        h20_lane_op_t o;
        o.neg   = xneg ^ f0[FW-1] ^ f1[FW-1] ^ f2[FW-1] ^ f3[FW-1];
        o.kcode = k;
        o.mag   = {fmag(f3), fmag(f2), fmag(f1), fmag(f0)};
        return o;
    endfunction

    always_comb begin
        logic [2:0][1:0]         c;
        logic signed [FW-1:0]    u [3];
        logic signed [FW-1:0]    t [3];
        logic signed [FW-1:0]    p [3];
        logic signed [FW-1:0]    sum, um, qa, qb;
        logic [1:0]              m, r;
        logic                    edge_node;
        c = node_pos(tag_in.node);
        edge_node = 1'b0;
        m = 2'd0;
        for (int d = 0; d < 3; d++) begin
            u[d] = {{(FW-16){coord[d][15]}}, coord[d]};
            case (c[d])
                2'b01:   t[d] = u[d];
                2'b11:   t[d] = -u[d];
                default: t[d] = '0;
            endcase
            p[d] = S_F + t[d];
            if (c[d] == 2'b00) begin
                edge_node = 1'b1;
                m = 2'(d);
            end
        end
        sum = t[0] + t[1] + t[2];
        um  = u[m];
        qa  = S_F - um;
        qb  = S_F + um;
        if (!edge_node) begin
            ops_next[0] = mk_op(p[0], p[1], p[2], sum - (S_F <<< 1), 1'b0, K_CORNER_VAL);
        end else begin
            case (m)
                2'd0:    ops_next[0] = mk_op(qa, qb, p[1], p[2], 1'b0, K_EDGE_VAL);
                2'd1:    ops_next[0] = mk_op(qa, qb, p[0], p[2], 1'b0, K_EDGE_VAL);
                default: ops_next[0] = mk_op(qa, qb, p[0], p[1], 1'b0, K_EDGE_VAL);
            endcase
        end
        for (int a = 0; a < 3; a++) begin
            // third axis r, the one that is neither the edge axis m nor axis a
            r = 2'(3 - int'(m) - a);
            if (r > 2'd2) begin
                r = 2'd0;
            end
            if (!edge_node) begin
                ops_next[a+1] = mk_op(ONE_F, p[(a+1)%3], p[(a+2)%3], sum + t[a] - S_F,
                                      c[a][1], K_CORNER_DER);
            end else if (m == 2'(a)) begin
                case (m)
                    2'd0:    ops_next[a+1] = mk_op(-um, p[1], p[2], ONE_F, 1'b0,
                                                   K_EDGE_AXIS);
                    2'd1:    ops_next[a+1] = mk_op(-um, p[0], p[2], ONE_F, 1'b0,
                                                   K_EDGE_AXIS);
                    default: ops_next[a+1] = mk_op(-um, p[0], p[1], ONE_F, 1'b0,
                                                   K_EDGE_AXIS);
                endcase
            end else begin
                ops_next[a+1] = mk_op(qa, qb, p[r], ONE_F, c[a][1], K_EDGE_SIDE);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg <= '0;
        end else if (en) begin
            tag_reg <= tag_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ops_reg <= ops_next;
        end
    end

    assign tag = tag_reg;
    assign ops = ops_reg;

endmodule

[rtl/h20_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h20_lane
// Four-stage product of four factor magnitudes, rounded to nearest with
// ties away from zero, signed and saturated to 17 bits.
// ----------------------------------------------------------------------------
module h20_lane
    import h20_pkg::*;
(
    input  logic               aclk,
    input  logic               en,
    input  h20_lane_op_t       op,
    output logic signed [16:0] result
);

    localparam int HW = 2 * MW;

    localparam int K_CV = 3 * FRAC_BITS + 3;
    localparam int K_CD = 2 * FRAC_BITS + 3;
    localparam int K_EV = 3 * FRAC_BITS + 2;
    localparam int K_EA = 2 * FRAC_BITS + 1;
    localparam int K_ES = 2 * FRAC_BITS + 2;

    logic [HW-1:0]    m1_reg, m2_reg;
    logic [HW+MW-1:0] plo_reg, phi_reg;
    logic [PW-1:0]    full_reg;
    logic [1:0]       neg_reg;
    logic             neg3_reg;
    logic [2:0]       k2_reg, k3_reg, k4_reg;
    logic signed [16:0] result_reg, result_next;

    always_comb begin
        logic [PW:0] rnd;
        case (k4_reg)
            K_CORNER_VAL: rnd = ({1'b0, full_reg} + ((PW+1)'(1) << (K_CV - 1))) >> K_CV;
            K_CORNER_DER: rnd = ({1'b0, full_reg} + ((PW+1)'(1) << (K_CD - 1))) >> K_CD;
            K_EDGE_VAL:   rnd = ({1'b0, full_reg} + ((PW+1)'(1) << (K_EV - 1))) >> K_EV;
            K_EDGE_AXIS:  rnd = ({1'b0, full_reg} + ((PW+1)'(1) << (K_EA - 1))) >> K_EA;
            K_EDGE_SIDE:  rnd = ({1'b0, full_reg} + ((PW+1)'(1) << (K_ES - 1))) >> K_ES;
            default:      rnd = '0;
        endcase
        if (neg3_reg) begin
            result_next = (rnd > (PW+1)'(65536)) ? -17'sd65536 : -signed'(rnd[16:0]);
        end else begin
            result_next = (rnd > (PW+1)'(65535)) ? 17'sd65535 : signed'(rnd[16:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m1_reg   <= HW'(op.mag[0]) * HW'(op.mag[1]);
            m2_reg   <= HW'(op.mag[2]) * HW'(op.mag[3]);
            k2_reg   <= op.kcode;
            neg_reg  <= {neg_reg[0], op.neg};
            plo_reg  <= (HW+MW)'(m1_reg) * (HW+MW)'(m2_reg[MW-1:0]);
            phi_reg  <= (HW+MW)'(m1_reg) * (HW+MW)'(m2_reg[HW-1:MW]);
            k3_reg   <= k2_reg;
            full_reg <= PW'(plo_reg) + (PW'(phi_reg) << MW);
            k4_reg   <= k3_reg;
            neg3_reg <= neg_reg[1];
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

[rtl/hex20_shape_function_eval.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex20_shape_function_eval
// Shape values and first derivatives of the 20-node serendipity hexahedron.
//
// Usage:
//   s_ channel: one transfer carries a reference point (xi, eta, zeta),
//   each signed with FRAC_BITS fraction bits.
//   m_ channel: each point gives twenty transfers, one per node in
//   quadratic-hexahedron order (corners, bottom, top, middle edges);
//   m_tlast marks node 19.
//   Throughput: one node per cycle while the pipeline is not held; the
//   next point is taken in the cycle the previous point's last node is
//   issued, so points stream with no gap.
//   The first node of a point passes the sequencer, which loads the
//   point, then the factor stage, two multiply stages, the sum stage
//   and the rounding stage.
//   Reset clears the sequencer and all valid bits; no point is in flight.
//   When m_tready is low while m_tvalid is high, the whole pipeline holds
//   and s_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module hex20_shape_function_eval
    import h20_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // coord_xi, coord_eta, coord_zeta
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,  // node_index, shape_value, deriv_xi, deriv_eta,
                                  // deriv_zeta, zero fill
    output logic        m_tlast
);

    logic                en;
    h20_tag_t            seq_tag, fac_tag;
    logic [2:0][15:0]    coord;
    h20_lane_op_t [3:0]  ops;
    logic signed [16:0]  res [4];
    h20_tag_t            tag_reg [4];

    assign en = !tag_reg[3].valid || m_tready;

    h20_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .coord_in ({s_tdata[47:32], s_tdata[31:16], s_tdata[15:0]}),
        .tag      (seq_tag),
        .coord    (coord)
    );

    h20_factor u_factor (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .tag_in  (seq_tag),
        .coord   (coord),
        .tag     (fac_tag),
        .ops     (ops)
    );

    for (genvar g = 0; g < 4; g++) begin : g_lane
        h20_lane u_lane (
            .aclk   (aclk),
            .en     (en),
            .op     (ops[g]),
            .result (res[g])
        );
    end

    // tags follow the four lane stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                tag_reg[i] <= '0;
            end
        end else if (en) begin
            tag_reg[0] <= fac_tag;
            for (int i = 1; i < 4; i++) begin
                tag_reg[i] <= tag_reg[i-1];
            end
        end
    end

    assign m_tvalid = tag_reg[3].valid;
    assign m_tlast  = tag_reg[3].node == LAST_NODE;
    assign m_tdata  = {7'd0, res[3], res[2], res[1], res[0], tag_reg[3].node};

    a_last_is_node19: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[4:0] == LAST_NODE)
        else $error("m_tlast on wrong node");

    a_accept_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> seq_tag.valid && seq_tag.node == 5'd0)
        else $error("sequencer did not restart on new point");

    a_no_accept_midpoint: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !seq_tag.valid || seq_tag.node == LAST_NODE)
        else $error("point accepted while nodes remain");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        tag_reg[2].valid && !en |=> tag_reg[2].valid)
        else $error("pipeline stage lost item during stall");

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks hex20_shape_function_eval against its own node-by-node predictor.
// Points are streamed in, in some phases with random input gaps and random
// result-side stalls. Each point is expected to give twenty node transfers,
// and every field of every node is compared.
// ----------------------------------------------------------------------------

typedef struct {
    logic [4:0]  node;
    logic [16:0] val [4];
    logic        last;
} node_result_t;

class shape_scoreboard;
    node_result_t expected_nodes[$];
    int           errors;
    int           points;
    int           nodes_seen;

    // exact product scaled by 2^-k, rounded half away from zero, saturated
    function automatic logic [16:0] round_scale(logic signed [127:0] prod, int k);
        logic         neg;
        logic [127:0] mag;
        logic [127:0] q;
        neg = prod < 0;
        mag = neg ? -prod : prod;
        q = (mag + (128'd1 << (k - 1))) >> k;
        if (neg) return (q > 65536) ? -17'sd65536 : 17'(-q);
        return (q > 65535) ? 17'd65535 : 17'(q);
    endfunction

    function automatic void note_point(int ux, int ue, int uz);
        int unsigned fb;
        logic signed [127:0] s;
        logic signed [127:0] u [3];
        logic signed [127:0] p [3];
        logic signed [127:0] sum, qa, qb, pe, pg;
        int c [3];
        int m, e, g;
        node_result_t r;
        fb = h20_pkg::FRAC_BITS;
        s = 128'sd1 <<< fb;
        u[0] = ux; u[1] = ue; u[2] = uz;
        for (int nd = 0; nd < 20; nd++) begin
            c[0] = (nd inside {0, 3, 4, 7, 11, 15, 16, 19}) ? -1 :
                   (nd inside {8, 10, 12, 14}) ? 0 : 1;
            c[1] = (nd inside {0, 1, 4, 5, 8, 12, 16, 17}) ? -1 :
                   (nd inside {9, 11, 13, 15}) ? 0 : 1;
            c[2] = (nd < 4 || (nd >= 8 && nd < 12)) ? -1 : (nd >= 16) ? 0 : 1;
            m = -1;
            for (int d = 0; d < 3; d++) if (c[d] == 0) m = d;
            if (m < 0) begin
                sum = 0;
                for (int d = 0; d < 3; d++) begin
                    p[d] = s + c[d] * u[d];
                    sum += c[d] * u[d];
                end
                r.val[0] = round_scale(p[0] * p[1] * p[2] * (sum - 2 * s), 3 * fb + 3);
                for (int d = 0; d < 3; d++) begin
                    e = (d + 1) % 3;
                    g = (d + 2) % 3;
                    r.val[1 + d] = round_scale(c[d] * p[e] * p[g] * (sum + c[d] * u[d] - s),
                                               2 * fb + 3);
                end
            end else begin
                e = (m + 1) % 3;
                g = (m + 2) % 3;
                pe = s + c[e] * u[e];
                pg = s + c[g] * u[g];
                qa = s - u[m];
                qb = s + u[m];
                r.val[0]     = round_scale(qa * qb * pe * pg, 3 * fb + 2);
                r.val[1 + m] = round_scale(-u[m] * pe * pg, 2 * fb + 1);
                r.val[1 + e] = round_scale(c[e] * qa * qb * pg, 2 * fb + 2);
                r.val[1 + g] = round_scale(c[g] * qa * qb * pe, 2 * fb + 2);
            end
            r.node = 5'(nd);
            r.last = (nd == 19);
            expected_nodes.push_back(r);
        end
        points++;
    endfunction

    function automatic void check_node(logic [79:0] data, logic last);
        node_result_t x;
        logic [16:0] got;
        string names [4] = '{"shape_value", "deriv_xi", "deriv_eta", "deriv_zeta"};
        nodes_seen++;
        if (expected_nodes.size() == 0) begin
            $error("unexpected node transfer, node_index %0d", data[4:0]);
            errors++;
            return;
        end
        x = expected_nodes.pop_front();
        if (data[4:0] !== x.node) begin
            $error("node_index: expected %0d, got %0d", x.node, data[4:0]);
            errors++;
        end
        for (int i = 0; i < 4; i++) begin
            got = data[5 + 17 * i +: 17];
            if (got !== x.val[i]) begin
                $error("%s (node %0d): expected %0d, got %0d", names[i], x.node,
                       $signed(x.val[i]), $signed(got));
                errors++;
            end
        end
        if (last !== x.last) begin
            $error("last_node (node %0d): expected %0d, got %0d", x.node, x.last, last);
            errors++;
        end
    endfunction
endclass

module testbench;
    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;
    logic        m_tlast;

    shape_scoreboard sb = new();
    int send_idle_pct;
    int recv_stall_pct;
    int hold_left;

    hex20_shape_function_eval dut (.*);

    always #5 aclk = ~aclk;

    // result side: random stall, or a long hold-off when requested
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready = 1'b0;
        end else if (hold_left > 0) begin
            m_tready = 1'b0;
            hold_left--;
        end else begin
            m_tready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_node(m_tdata, m_tlast);
    end

    task automatic send_point(logic [15:0] xi, logic [15:0] eta, logic [15:0] zeta);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = {zeta, eta, xi};
        do @(posedge aclk); while (!s_tready);
        sb.note_point($signed(xi), $signed(eta), $signed(zeta));
    endtask

    task automatic drain;
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (sb.expected_nodes.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    function automatic logic [15:0] rand_coord;
        int r;
        r = $urandom_range(99);
        if (r < 80) return 16'($signed($urandom_range(32768)) - 16384);
        if (r < 90) return 16'($urandom);
        return 16'(($urandom_range(1) ? 16384 : -16384));
    endfunction

    initial begin
        logic [15:0] dir [10] = '{16'h0000, 16'h4000, 16'hc000, 16'h7fff, 16'h8000,
                                 16'h2000, 16'he000, 16'h0001, 16'hffff, 16'h5555};
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: nodes, center, faces, out-of-range extremes
        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < 10; i++) send_point(dir[i], dir[i], dir[i]);
        for (int i = 0; i < 10; i++) send_point(dir[i], dir[(i + 3) % 10], dir[(i + 7) % 10]);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 1) ? 66 : 31) : 0;
            recv_stall_pct = (ph == 2) ? 66 : (ph == 3) ? 31 : 0;
            if (ph == 0) hold_left = 300;
            for (int i = 0; i < 110; i++) send_point(rand_coord(), rand_coord(), rand_coord());
            drain();
        end

        $display("covered %0d points, %0d node transfers, under idle and stall phases",
                 sb.points, sb.nodes_seen);
        if (sb.errors == 0 && sb.expected_nodes.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end
endmodule

[filelist.f]
rtl/h20_pkg.sv
rtl/h20_seq.sv
rtl/h20_factor.sv
rtl/h20_lane.sv
rtl/hex20_shape_function_eval.sv
tb/sv/testbench.sv
